// ----- rtl/debounced_button_frequency_tuner_macros.svh -----
`ifndef DEBOUNCED_BUTTON_FREQUENCY_TUNER_MACROS_SVH
`define DEBOUNCED_BUTTON_FREQUENCY_TUNER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DBFT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("dbft assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define DBFT_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  `DBFT_ASSERT(label, clk, rst_n, (cond) |-> (cons))

`endif

// ----- rtl/dbft_pkg.sv -----
`timescale 1ns / 1ps

package dbft_pkg;

  localparam int unsigned NumButtons = 3;
  localparam int unsigned FreqW      = 28;
  localparam int unsigned StepW      = 20;
  localparam int unsigned MsW        = 16;
  localparam int unsigned InTimeW    = 32;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned IdxW       = 3;

  localparam int unsigned BtnMode = 0;
  localparam int unsigned BtnDown = 1;
  localparam int unsigned BtnUp   = 2;

  typedef enum logic [IdxW-1:0] {
    RegMinFreq     = 3'd0,
    RegMaxFreq     = 3'd1,
    RegNormalStep  = 3'd2,
    RegFineStep    = 3'd3,
    RegDebounce    = 3'd4,
    RegRepeatDelay = 3'd5,
    RegRepeatRate  = 3'd6
  } reg_idx_e;

  localparam logic [FreqW-1:0] MinFreqRst     = 28'd7000000;
  localparam logic [FreqW-1:0] MaxFreqRst     = 28'd7030000;
  localparam logic [StepW-1:0] NormalStepRst  = 20'd1000;
  localparam logic [StepW-1:0] FineStepRst    = 20'd100;
  localparam logic [MsW-1:0]   DebounceRst    = 16'd30;
  localparam logic [MsW-1:0]   RepeatDelayRst = 16'd1000;
  localparam logic [MsW-1:0]   RepeatRateRst  = 16'd150;
  localparam logic [FreqW-1:0] FreqRst        = 28'd7015000;

  typedef struct packed {
    logic [FreqW-1:0] min_freq;
    logic [FreqW-1:0] max_freq;
    logic [StepW-1:0] normal_step;
    logic [StepW-1:0] fine_step;
    logic [MsW-1:0]   debounce_ms;
    logic [MsW-1:0]   repeat_delay_ms;
    logic [MsW-1:0]   repeat_rate_ms;
  } cfg_t;

  typedef struct packed {
    logic press;
    logic rel;
    logic rpt;
  } btn_ev_t;

  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic             changed;
    logic             fine;
  } tune_res_t;

endpackage

// ----- rtl/dbft_if.sv -----
`timescale 1ns / 1ps

interface dbft_in_if;
  logic                              valid;
  logic                              ready;
  logic [dbft_pkg::InTimeW-1:0]      time_ms;
  logic                              key_level;
  logic                              mode_button;
  logic                              down_button;
  logic                              up_button;

  modport source (
    output valid, time_ms, key_level, mode_button, down_button, up_button,
    input  ready
  );
  modport sink (
    input  valid, time_ms, key_level, mode_button, down_button, up_button,
    output ready
  );
endinterface

interface dbft_out_if;
  logic                          valid;
  logic                          ready;
  logic [dbft_pkg::FreqW-1:0]    freq_hz;
  logic                          freq_changed;
  logic                          fine_mode;
  logic                          tx_enable;
  logic [dbft_pkg::NumButtons-1:0] pressed_mask;
  logic [dbft_pkg::NumButtons-1:0] released_mask;
  logic [dbft_pkg::NumButtons-1:0] repeat_mask;

  modport source (
    output valid, freq_hz, freq_changed, fine_mode, tx_enable,
           pressed_mask, released_mask, repeat_mask,
    input  ready
  );
  modport sink (
    input  valid, freq_hz, freq_changed, fine_mode, tx_enable,
           pressed_mask, released_mask, repeat_mask,
    output ready
  );
endinterface

// ----- rtl/dbft_cfg_regs.sv -----
`timescale 1ns / 1ps

module dbft_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbft_pkg::AddrW-1:0]    paddr,
  input  logic [dbft_pkg::DataW-1:0]    pwdata,
  output logic [dbft_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output dbft_pkg::cfg_t                cfg_o
);

  dbft_pkg::cfg_t     cfg_q;
  dbft_pkg::cfg_t     cfg_d;
  dbft_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = dbft_pkg::reg_idx_e'(paddr[dbft_pkg::AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        dbft_pkg::RegMinFreq:     cfg_d.min_freq        = pwdata[dbft_pkg::FreqW-1:0];
        dbft_pkg::RegMaxFreq:     cfg_d.max_freq        = pwdata[dbft_pkg::FreqW-1:0];
        dbft_pkg::RegNormalStep:  cfg_d.normal_step     = pwdata[dbft_pkg::StepW-1:0];
        dbft_pkg::RegFineStep:    cfg_d.fine_step       = pwdata[dbft_pkg::StepW-1:0];
        dbft_pkg::RegDebounce:    cfg_d.debounce_ms     = pwdata[dbft_pkg::MsW-1:0];
        dbft_pkg::RegRepeatDelay: cfg_d.repeat_delay_ms = pwdata[dbft_pkg::MsW-1:0];
        dbft_pkg::RegRepeatRate:  cfg_d.repeat_rate_ms  = pwdata[dbft_pkg::MsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dbft_pkg::RegMinFreq:     prdata = dbft_pkg::DataW'(cfg_q.min_freq);
      dbft_pkg::RegMaxFreq:     prdata = dbft_pkg::DataW'(cfg_q.max_freq);
      dbft_pkg::RegNormalStep:  prdata = dbft_pkg::DataW'(cfg_q.normal_step);
      dbft_pkg::RegFineStep:    prdata = dbft_pkg::DataW'(cfg_q.fine_step);
      dbft_pkg::RegDebounce:    prdata = dbft_pkg::DataW'(cfg_q.debounce_ms);
      dbft_pkg::RegRepeatDelay: prdata = dbft_pkg::DataW'(cfg_q.repeat_delay_ms);
      dbft_pkg::RegRepeatRate:  prdata = dbft_pkg::DataW'(cfg_q.repeat_rate_ms);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_freq        <= dbft_pkg::MinFreqRst;
      cfg_q.max_freq        <= dbft_pkg::MaxFreqRst;
      cfg_q.normal_step     <= dbft_pkg::NormalStepRst;
      cfg_q.fine_step       <= dbft_pkg::FineStepRst;
      cfg_q.debounce_ms     <= dbft_pkg::DebounceRst;
      cfg_q.repeat_delay_ms <= dbft_pkg::RepeatDelayRst;
      cfg_q.repeat_rate_ms  <= dbft_pkg::RepeatRateRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/dbft_debounce.sv -----
`timescale 1ns / 1ps

module dbft_debounce #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [TIME_WIDTH-1:0]       now_i,
  input  logic                        level_i,
  input  logic [dbft_pkg::MsW-1:0]    debounce_ms_i,
  input  logic [dbft_pkg::MsW-1:0]    repeat_delay_ms_i,
  input  logic [dbft_pkg::MsW-1:0]    repeat_rate_ms_i,
  output dbft_pkg::btn_ev_t           ev_o
);

  logic                  last_q, last_d;
  logic                  stable_q, stable_d;
  logic [TIME_WIDTH-1:0] change_q, change_d;
  logic [TIME_WIDTH-1:0] press_q, press_d;
  logic [TIME_WIDTH-1:0] rpt_q, rpt_d;
  logic                  accept;
  logic                  rpt;

  always_comb begin
    last_d   = level_i;
    change_d = (level_i != last_q) ? now_i : change_q;
    accept   = (level_i != stable_q) &&
               ((now_i - change_d) >= TIME_WIDTH'(debounce_ms_i));
    stable_d = accept ? level_i : stable_q;
    press_d  = (accept && !level_i) ? now_i : press_q;
    rpt     = !stable_d &&
               ((now_i - press_d) >= TIME_WIDTH'(repeat_delay_ms_i)) &&
               ((now_i - ((accept && !level_i) ? now_i : rpt_q)) >=
                TIME_WIDTH'(repeat_rate_ms_i));
    rpt_d    = (rpt || (accept && !level_i)) ? now_i : rpt_q;
    ev_o.press = accept && !level_i;
    ev_o.rel   = accept && level_i;
    ev_o.rpt   = rpt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      change_q <= '0;
      press_q  <= '0;
      rpt_q    <= '0;
    end else if (adv_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      change_q <= change_d;
      press_q  <= press_d;
      rpt_q    <= rpt_d;
    end
  end

endmodule

// ----- rtl/dbft_tune.sv -----
`timescale 1ns / 1ps

module dbft_tune (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic [dbft_pkg::NumButtons-1:0] press_i,
  input  logic [dbft_pkg::NumButtons-1:0] rpt_i,
  input  dbft_pkg::cfg_t                  cfg_i,
  output dbft_pkg::tune_res_t             res_o
);

  logic [dbft_pkg::FreqW-1:0] freq_q, freq_d;
  logic                       fine_q, fine_d;
  logic [dbft_pkg::StepW-1:0] step;
  logic [dbft_pkg::FreqW:0]   down_lim;
  logic [dbft_pkg::FreqW:0]   up_sum;
  logic [dbft_pkg::FreqW-1:0] f_down;
  logic                       do_down, do_up;

  always_comb begin
    fine_d   = fine_q ^ press_i[dbft_pkg::BtnMode];
    step     = fine_d ? cfg_i.fine_step : cfg_i.normal_step;
    do_down  = press_i[dbft_pkg::BtnDown] || rpt_i[dbft_pkg::BtnDown];
    do_up    = press_i[dbft_pkg::BtnUp] || rpt_i[dbft_pkg::BtnUp];
    down_lim = {1'b0, cfg_i.min_freq} + (dbft_pkg::FreqW+1)'(step);
    f_down   = freq_q;
    if (do_down) begin
      f_down = ({1'b0, freq_q} >= down_lim)
             ? freq_q - dbft_pkg::FreqW'(step) : cfg_i.min_freq;
    end
    up_sum = {1'b0, f_down} + (dbft_pkg::FreqW+1)'(step);
    freq_d = f_down;
    if (do_up) begin
      freq_d = (up_sum <= {1'b0, cfg_i.max_freq})
             ? up_sum[dbft_pkg::FreqW-1:0] : cfg_i.max_freq;
    end
    res_o.freq    = freq_d;
    res_o.changed = freq_d != freq_q;
    res_o.fine    = fine_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= dbft_pkg::FreqRst;
      fine_q <= 1'b0;
    end else if (adv_i) begin
      freq_q <= freq_d;
      fine_q <= fine_d;
    end
  end

endmodule

// ----- rtl/debounced_button_frequency_tuner.sv -----
`timescale 1ns / 1ps
// An accepted sample waits in the input register until the output register is free.
// Throughput: one sample per cycle while out_o.ready holds; the button and frequency
// state update in the same cycle the sample leaves the input register.
// Reset (rst_ni, async, active low): pipeline empty, registers at defaults,
// buttons released with zero times, frequency 7015000 Hz, normal step.

module debounced_button_frequency_tuner #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dbft_in_if.sink                    in_i,
  dbft_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dbft_pkg::AddrW-1:0] paddr,
  input  logic [dbft_pkg::DataW-1:0] pwdata,
  output logic [dbft_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  dbft_pkg::cfg_t                  cfg;
  dbft_pkg::btn_ev_t               ev [dbft_pkg::NumButtons];
  dbft_pkg::tune_res_t             res;
  logic [dbft_pkg::NumButtons-1:0] pm, rm, xm;

  logic                            s1_valid_q, s1_valid_d;
  logic [TIME_WIDTH-1:0]           s1_time_q;
  logic                            s1_key_q;
  logic [dbft_pkg::NumButtons-1:0] s1_btn_q;
  logic                            out_valid_q, out_valid_d;
  logic                            adv, in_hs;

  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_hs      = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d  = in_hs ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
    out_valid_d = adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      s1_time_q                   <= in_i.time_ms[TIME_WIDTH-1:0];
      s1_key_q                    <= in_i.key_level;
      s1_btn_q[dbft_pkg::BtnMode] <= in_i.mode_button;
      s1_btn_q[dbft_pkg::BtnDown] <= in_i.down_button;
      s1_btn_q[dbft_pkg::BtnUp]   <= in_i.up_button;
    end
  end

  dbft_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  for (genvar b = 0; b < dbft_pkg::NumButtons; b++) begin : g_btn
    dbft_debounce #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_deb (
      .clk_i             (clk_i),
      .rst_ni            (rst_ni),
      .adv_i             (adv),
      .now_i             (s1_time_q),
      .level_i           (s1_btn_q[b]),
      .debounce_ms_i     (cfg.debounce_ms),
      .repeat_delay_ms_i (cfg.repeat_delay_ms),
      .repeat_rate_ms_i  (cfg.repeat_rate_ms),
      .ev_o              (ev[b])
    );
    assign pm[b] = ev[b].press;
    assign rm[b] = ev[b].rel;
    assign xm[b] = ev[b].rpt;
  end

  dbft_tune u_tune (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .press_i (pm),
    .rpt_i   (xm),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_o.freq_hz       <= res.freq;
      out_o.freq_changed  <= res.changed;
      out_o.fine_mode     <= res.fine;
      out_o.tx_enable     <= !s1_key_q;
      out_o.pressed_mask  <= pm;
      out_o.released_mask <= rm;
      out_o.repeat_mask   <= xm;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// ----- rtl/dbft_checker.sv -----
`timescale 1ns / 1ps
`include "debounced_button_frequency_tuner_macros.svh"

module dbft_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dbft_pkg::FreqW-1:0]      freq_hz,
  input logic                            freq_changed,
  input logic                            fine_mode,
  input logic [dbft_pkg::NumButtons-1:0] pressed_mask,
  input logic [dbft_pkg::NumButtons-1:0] released_mask
);

  logic [dbft_pkg::FreqW-1:0] last_freq_q;
  logic                       last_fine_q;
  logic                       out_hs;

  assign out_hs = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_freq_q <= dbft_pkg::FreqRst;
      last_fine_q <= 1'b0;
    end else if (out_hs) begin
      last_freq_q <= freq_hz;
      last_fine_q <= fine_mode;
    end
  end

  `DBFT_ASSERT_IMP(a_changed_flag, clk_i, rst_ni, out_hs, freq_changed == (freq_hz != last_freq_q))
  `DBFT_ASSERT_IMP(a_fine_toggle, clk_i, rst_ni, out_hs, fine_mode == (last_fine_q ^ pressed_mask[dbft_pkg::BtnMode]))
  `DBFT_ASSERT_IMP(a_press_rel_excl, clk_i, rst_ni, out_valid, (pressed_mask & released_mask) == '0)
  `DBFT_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid, in_ready)
  `DBFT_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(freq_hz))

endmodule

bind debounced_button_frequency_tuner dbft_checker u_dbft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .freq_hz       (out_o.freq_hz),
  .freq_changed  (out_o.freq_changed),
  .fine_mode     (out_o.fine_mode),
  .pressed_mask  (out_o.pressed_mask),
  .released_mask (out_o.released_mask)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import dbft_pkg::*;

  localparam int unsigned DirRows  = 25;
  localparam int unsigned MaxShown = 10;

  typedef struct packed {
    logic [InTimeW-1:0] time_ms;
    logic               key;
    logic               mode;
    logic               down;
    logic               up;
  } sample_t;

  typedef struct packed {
    logic [FreqW-1:0]      freq;
    logic                  changed;
    logic                  fine;
    logic                  tx;
    logic [NumButtons-1:0] pressed;
    logic [NumButtons-1:0] released;
    logic [NumButtons-1:0] repeated;
  } tuner_out_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  dbft_in_if  in_bus ();
  dbft_out_if out_bus ();

  debounced_button_frequency_tuner u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // tracked copy of the block's registers and state
  cfg_t                  cfg;
  logic [FreqW-1:0]      trk_freq;
  logic                  trk_fine;
  logic [NumButtons-1:0] btn_stable;
  logic [NumButtons-1:0] btn_last;
  logic [InTimeW-1:0]    chg_ms   [NumButtons];
  logic [InTimeW-1:0]    press_ms [NumButtons];
  logic [InTimeW-1:0]    rpt_ms   [NumButtons];

  tuner_out_t tuner_out_q [$];
  sample_t    dir_stim  [DirRows];
  tuner_out_t dir_typed [3];

  int unsigned err_cnt;
  int unsigned n_samples;
  int unsigned n_results;
  int unsigned n_press;
  int unsigned n_repeat;
  int unsigned n_settings;
  int unsigned rx_cyc;

  logic [InTimeW-1:0]    stim_ms;
  logic [NumButtons-1:0] stim_lvl;
  logic                  stim_key;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [InTimeW-1:0] since(input logic [InTimeW-1:0] now,
                                               input logic [InTimeW-1:0] then_ms);
    return now - then_ms;
  endfunction

  function automatic tuner_out_t advance_tuner(input sample_t s);
    tuner_out_t            r;
    logic [NumButtons-1:0] lv;
    logic [FreqW-1:0]      prev;
    logic [StepW-1:0]      step;
    lv   = {s.up, s.down, s.mode};
    prev = trk_freq;
    r    = '0;
    for (int b = 0; b < NumButtons; b++) begin
      if (lv[b] != btn_last[b]) begin
        btn_last[b] = lv[b];
        chg_ms[b]   = s.time_ms;
      end
      if (lv[b] != btn_stable[b] &&
          since(s.time_ms, chg_ms[b]) >= InTimeW'(cfg.debounce_ms)) begin
        btn_stable[b] = lv[b];
        if (!lv[b]) begin
          press_ms[b]  = s.time_ms;
          rpt_ms[b]    = s.time_ms;
          r.pressed[b] = 1'b1;
        end else begin
          r.released[b] = 1'b1;
        end
      end
      if (!btn_stable[b] &&
          since(s.time_ms, press_ms[b]) >= InTimeW'(cfg.repeat_delay_ms) &&
          since(s.time_ms, rpt_ms[b]) >= InTimeW'(cfg.repeat_rate_ms)) begin
        rpt_ms[b]     = s.time_ms;
        r.repeated[b] = 1'b1;
      end
    end
    if (r.pressed[BtnMode]) trk_fine = ~trk_fine;
    step = trk_fine ? cfg.fine_step : cfg.normal_step;
    if (r.pressed[BtnDown] || r.repeated[BtnDown]) begin
      if (64'(trk_freq) >= 64'(cfg.min_freq) + 64'(step)) trk_freq = trk_freq - step;
      else trk_freq = cfg.min_freq;
    end
    if (r.pressed[BtnUp] || r.repeated[BtnUp]) begin
      if (64'(trk_freq) + 64'(step) <= 64'(cfg.max_freq)) trk_freq = trk_freq + step;
      else trk_freq = cfg.max_freq;
    end
    r.freq    = trk_freq;
    r.changed = (trk_freq != prev);
    r.fine    = trk_fine;
    r.tx      = ~s.key;
    return r;
  endfunction

  task automatic cfg_write(input reg_idx_e idx, input logic [DataW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegMinFreq:     cfg.min_freq        = val[FreqW-1:0];
      RegMaxFreq:     cfg.max_freq        = val[FreqW-1:0];
      RegNormalStep:  cfg.normal_step     = val[StepW-1:0];
      RegFineStep:    cfg.fine_step       = val[StepW-1:0];
      RegDebounce:    cfg.debounce_ms     = val[MsW-1:0];
      RegRepeatDelay: cfg.repeat_delay_ms = val[MsW-1:0];
      RegRepeatRate:  cfg.repeat_rate_ms  = val[MsW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_all(input logic [DataW-1:0] min_f, input logic [DataW-1:0] max_f,
                         input logic [DataW-1:0] nstep, input logic [DataW-1:0] fstep,
                         input logic [DataW-1:0] deb, input logic [DataW-1:0] dly,
                         input logic [DataW-1:0] rate);
    cfg_write(RegMinFreq, min_f);
    cfg_write(RegMaxFreq, max_f);
    cfg_write(RegNormalStep, nstep);
    cfg_write(RegFineStep, fstep);
    cfg_write(RegDebounce, deb);
    cfg_write(RegRepeatDelay, dly);
    cfg_write(RegRepeatRate, rate);
    n_settings++;
  endtask

  task automatic pause(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
  endtask

  // hold valid low until every expected item is back, then let the pipe settle
  task automatic drain();
    pause(1);
    while (tuner_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_sample(input sample_t s, input logic use_typed, input tuner_out_t typed);
    tuner_out_t r;
    @(negedge clk_i);
    in_bus.valid       <= 1'b1;
    in_bus.time_ms     <= s.time_ms;
    in_bus.key_level   <= s.key;
    in_bus.mode_button <= s.mode;
    in_bus.down_button <= s.down;
    in_bus.up_button   <= s.up;
    do @(posedge clk_i); while (!in_bus.ready);
    r = advance_tuner(s);
    if (use_typed) r = typed;
    tuner_out_q.push_back(r);
    n_samples++;
  endtask

  task automatic run_random(input int unsigned cnt, input int unsigned dmax);
    int unsigned burst_left;
    sample_t     s;
    burst_left = 0;
    for (int unsigned n = 0; n < cnt; n++) begin
      if (n == cnt / 2) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
      end
      burst_left--;
      if ($urandom_range(0, 19) == 0) begin
        stim_ms  = $urandom;
        stim_key = $urandom_range(0, 1);
        s = '{stim_ms, stim_key, 1'($urandom), 1'($urandom), 1'($urandom)};
      end else begin
        stim_ms = stim_ms + $urandom_range(0, dmax);
        for (int b = 0; b < NumButtons; b++)
          if ($urandom_range(0, 11) == 0) stim_lvl[b] = ~stim_lvl[b];
        if ($urandom_range(0, 7) == 0) stim_key = ~stim_key;
        s = '{stim_ms, stim_key, stim_lvl[BtnMode], stim_lvl[BtnDown], stim_lvl[BtnUp]};
        if ($urandom_range(0, 9) == 0) begin
          s.mode = s.mode ^ 1'($urandom);
          s.down = s.down ^ 1'($urandom);
          s.up   = s.up ^ 1'($urandom);
        end
      end
      push_sample(s, 1'b0, '0);
    end
  endtask

  initial begin
    out_bus.ready = 1'b0;
    rx_cyc = 0;
    forever begin
      @(negedge clk_i);
      rx_cyc++;
      case ((rx_cyc >> 8) % 4)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        2: out_bus.ready <= ((rx_cyc % 7) >= 2);
        default: out_bus.ready <= ($urandom_range(0, 9) > 5);
      endcase
    end
  end

  always @(posedge clk_i) begin
    tuner_out_t got;
    tuner_out_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.freq_hz, out_bus.freq_changed, out_bus.fine_mode, out_bus.tx_enable,
              out_bus.pressed_mask, out_bus.released_mask, out_bus.repeat_mask};
      n_results++;
      n_press  += $countones(got.pressed);
      n_repeat += $countones(got.repeated);
      if (tuner_out_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxShown)
          $display("%0t: unexpected item freq=%0d", $realtime, got.freq);
      end else begin
        want = tuner_out_q.pop_front();
        if (got != want) begin
          err_cnt++;
          if (err_cnt <= MaxShown)
            $display({"%0t: mismatch exp freq=%0d chg=%b fine=%b tx=%b prs=%b rel=%b rpt=%b",
                      " | act freq=%0d chg=%b fine=%b tx=%b prs=%b rel=%b rpt=%b"},
                     $realtime, want.freq, want.changed, want.fine, want.tx, want.pressed,
                     want.released, want.repeated, got.freq, got.changed, got.fine, got.tx,
                     got.pressed, got.released, got.repeated);
        end
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_bus.valid       = 1'b0;
    in_bus.time_ms     = '0;
    in_bus.key_level   = 1'b1;
    in_bus.mode_button = 1'b1;
    in_bus.down_button = 1'b1;
    in_bus.up_button   = 1'b1;
    err_cnt    = 0;
    n_samples  = 0;
    n_results  = 0;
    n_press    = 0;
    n_repeat   = 0;
    n_settings = 1;

    cfg = '{MinFreqRst, MaxFreqRst, NormalStepRst, FineStepRst,
            DebounceRst, RepeatDelayRst, RepeatRateRst};
    trk_freq   = FreqRst;
    trk_fine   = 1'b0;
    btn_stable = '1;
    btn_last   = '1;
    for (int b = 0; b < NumButtons; b++) begin
      chg_ms[b]   = '0;
      press_ms[b] = '0;
      rpt_ms[b]   = '0;
    end

    // time, key, mode, down, up
    dir_stim[0]  = '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[1]  = '{32'h0000_0001, 1'b0, 1'b1, 1'b1, 1'b1};
    dir_stim[2]  = '{32'h0000_0002, 1'b1, 1'b1, 1'b1, 1'b0};
    dir_stim[3]  = '{32'd32,        1'b1, 1'b1, 1'b1, 1'b0};
    dir_stim[4]  = '{32'd1032,      1'b1, 1'b1, 1'b1, 1'b0};
    dir_stim[5]  = '{32'd1100,      1'b0, 1'b1, 1'b1, 1'b0};
    dir_stim[6]  = '{32'd1182,      1'b1, 1'b1, 1'b1, 1'b0};
    dir_stim[7]  = '{32'd1190,      1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[8]  = '{32'd1195,      1'b1, 1'b1, 1'b1, 1'b0};
    dir_stim[9]  = '{32'd1210,      1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[10] = '{32'd1240,      1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[11] = '{32'd1300,      1'b1, 1'b0, 1'b1, 1'b1};
    dir_stim[12] = '{32'd1330,      1'b1, 1'b0, 1'b1, 1'b1};
    dir_stim[13] = '{32'd1400,      1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[14] = '{32'd1430,      1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[15] = '{32'd1500,      1'b1, 1'b1, 1'b0, 1'b0};
    dir_stim[16] = '{32'd1530,      1'b0, 1'b1, 1'b0, 1'b0};
    dir_stim[17] = '{32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[18] = '{32'h0000_000E, 1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[19] = '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1};
    dir_stim[20] = '{32'h0000_001D, 1'b0, 1'b0, 1'b1, 1'b1};
    dir_stim[21] = '{32'h0000_0100, 1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[22] = '{32'h0000_011E, 1'b1, 1'b1, 1'b1, 1'b1};
    dir_stim[23] = '{32'h0000_0200, 1'b1, 1'b0, 1'b0, 1'b1};
    dir_stim[24] = '{32'h0000_021E, 1'b1, 1'b0, 1'b0, 1'b1};
    dir_typed[0] = '{FreqRst, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, 3'b000};
    dir_typed[1] = '{FreqRst, 1'b0, 1'b0, 1'b1, 3'b000, 3'b000, 3'b000};
    dir_typed[2] = '{FreqRst, 1'b0, 1'b0, 1'b0, 3'b000, 3'b000, 3'b000};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      push_sample(dir_stim[i], (i < 3), (i < 3) ? dir_typed[i] : tuner_out_t'('0));
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 3));
    end
    stim_ms  = dir_stim[DirRows-1].time_ms;
    stim_lvl = '1;
    stim_key = 1'b1;

    for (int p = 0; p < 7; p++) begin
      if (p > 0) drain();
      case (p)
        0: run_random(150, 25);
        1: begin
          cfg_all(32'd0, 32'h0FFF_FFFF, 32'd1000000, 32'd1, 32'd0, 32'd0, 32'd0);
          run_random(180, 3);
        end
        2: begin
          // limits swapped, zero normal step, bits above the field widths set
          cfg_all(32'hF06B_1E60, 32'd7010000, 32'd0, 32'hFFFF_FFFF,
                  32'd5, 32'd40, 32'd10);
          run_random(150, 8);
        end
        3: begin
          cfg_all(32'd100, 32'd2000000, 32'd1000000, 32'd999999,
                  32'hFFFF, 32'hFFFF, 32'hFFFF);
          stim_ms = 32'hFFFF_0000;
          run_random(150, 40000);
        end
        4, 5: begin
          logic [DataW-1:0] lo;
          lo = $urandom_range(0, 200000000);
          cfg_all(lo, lo + $urandom_range(0, 5000000), $urandom_range(1, 1000000),
                  $urandom_range(1, 1000000), $urandom_range(0, 40),
                  $urandom_range(0, 400), $urandom_range(0, 80));
          run_random(150, 20);
        end
        default: begin
          cfg_all(MinFreqRst, MaxFreqRst, NormalStepRst, FineStepRst,
                  DebounceRst, RepeatDelayRst, RepeatRateRst);
          run_random(150, 25);
        end
      endcase
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d samples under %0d register settings, %0d results checked,",
             n_samples, n_settings, n_results);
    $display("with %0d press and %0d auto-repeat events seen; %0d mismatches.",
             n_press, n_repeat, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
